// ===== rtl/core/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
// No dependencies; used by every module of the block through scoped names.
package cbm_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_PRG    = 2'd1,
      ACT_CHR    = 2'd2,
      ACT_RELOAD = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RUN  = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic rem_last;
   } status_type;

   // configuration register indexes
   localparam logic [1:0] CSR_PRG_PAGES     = 2'd0;
   localparam logic [1:0] CSR_CHR_PAGES     = 2'd1;
   localparam logic [1:0] CSR_MIRROR_WIRING = 2'd2;

   // mapper register codes from bus address bits 1..0 (bit 13 low)
   localparam logic [1:0] REG_PRG_LOW = 2'd0;
   localparam logic [1:0] REG_PRG_HIGH = 2'd1;
   localparam logic [1:0] REG_CHR_BIG0 = 2'd2;
   localparam logic [1:0] REG_CHR_BIG1 = 2'd3;

   // 8KB PRG windows from bus address bits 14..13
   localparam logic [1:0] WIN_SEL_LOW      = 2'd0;
   localparam logic [1:0] WIN_SEL_HIGH     = 2'd1;
   localparam logic [1:0] WIN_FIXED_PENULT = 2'd2;
   localparam logic [1:0] WIN_FIXED_LAST   = 2'd3;

   // header mirroring codes
   localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
   localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
   localparam logic [1:0] MIRROR_FOUR       = 2'd2;

   localparam logic [8:0] MAX_PRG_PAGES = 9'd256;
   localparam logic [9:0] MAX_CHR_PAGES = 10'd512;

   localparam logic [8:0] PRG_PAGES_RESET = 9'd2;
   localparam logic [9:0] CHR_PAGES_RESET = 10'd8;

   // remainder unit: 8-bit dividend, 10-bit divisor, two bits per cycle
   localparam int DVD_WIDTH     = 8;
   localparam int DVS_WIDTH     = 10;
   localparam int BITS_PER_STEP = 2;
   localparam int REM_STEPS     = DVD_WIDTH / BITS_PER_STEP;
   localparam int CNT_WIDTH     = $clog2(REM_STEPS);

endpackage

// ===== rtl/core/cbm_ctrl.sv =====
// Sequencer for the cartridge bank mapper.
// Depends on cbm_pkg; drives datapath commands from the remainder unit status.
module cbm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cbm_pkg::status_type  status,
   output cbm_pkg::cmd_type     cmd
);

   cbm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbm_pkg::ST_IDLE: begin
            if (start) state_in = cbm_pkg::ST_RUN;
         end
         cbm_pkg::ST_RUN: begin
            if (status.rem_last) state_in = cbm_pkg::ST_DONE;
         end
         cbm_pkg::ST_DONE: begin
            state_in = cbm_pkg::ST_IDLE;
         end
         default: begin
            state_in = cbm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         cbm_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         cbm_pkg::ST_RUN: begin
            cmd.step = 1'b1;
         end
         cbm_pkg::ST_DONE: begin
            cmd.finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/cbm_rem_unit.sv =====
// Iterative restoring remainder: dividend mod divisor, two bits a cycle while step is high.
// Depends on cbm_pkg for widths and step count.
module cbm_rem_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic                              step,
   input  logic [cbm_pkg::DVD_WIDTH-1:0]     dividend,
   input  logic [cbm_pkg::DVS_WIDTH-1:0]     divisor,
   output logic [cbm_pkg::DVS_WIDTH-1:0]     remainder,
   output logic                              last
);

   logic [cbm_pkg::DVS_WIDTH-1:0] rem_ff, rem_in;
   logic [cbm_pkg::DVD_WIDTH-1:0] dvd_ff, dvd_in;
   logic [cbm_pkg::DVS_WIDTH-1:0] dvs_ff, dvs_in;
   logic [cbm_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;

   always_comb begin
      logic [cbm_pkg::DVS_WIDTH-1:0] r;
      logic [cbm_pkg::DVS_WIDTH-1:0] t;
      logic [cbm_pkg::DVD_WIDTH-1:0] d;
      r      = rem_ff;
      d      = dvd_ff;
      t      = '0;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rem_in = '0;
         dvd_in = dividend;
         dvs_in = divisor;
         cnt_in = '0;
      end else if (step) begin
         // remainder stays below the divisor, so the top bit is free to shift out
         for (int i = 0; i < cbm_pkg::BITS_PER_STEP; i++) begin
            t = {r[cbm_pkg::DVS_WIDTH-2:0], d[cbm_pkg::DVD_WIDTH-1]};
            d = {d[cbm_pkg::DVD_WIDTH-2:0], 1'b0};
            r = (t >= dvs_ff) ? (t - dvs_ff) : t;
         end
         rem_in = r;
         dvd_in = d;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign remainder = rem_ff;
   assign last      = (cnt_ff == cbm_pkg::CNT_WIDTH'(cbm_pkg::REM_STEPS - 1));

endmodule

// ===== rtl/core/cbm_datapath.sv =====
// Datapath of the cartridge bank mapper: configuration, bank selects,
// request capture, remainder unit and result registers. Depends on cbm_pkg.
module cbm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  cbm_pkg::cmd_type     cmd,
   output cbm_pkg::status_type  status,
   input  logic [1:0]           req_action,
   input  logic [15:0]          req_bus_addr,
   input  logic [7:0]           req_write_data,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_write_data,
   output logic                 rsp_strobe,
   output logic [20:0]          rsp_mapped_addr,
   output logic                 rsp_mirror_horizontal,
   output logic                 rsp_mirror_fixed,
   output logic                 rsp_chr_is_ram
);

   // configuration
   logic [8:0] prg_pages_ff, prg_pages_in;
   logic [9:0] chr_pages_ff, chr_pages_in;
   logic [1:0] mirror_wiring_ff, mirror_wiring_in;

   // bank selects
   logic [5:0] prg_low_ff, prg_low_in;
   logic [5:0] prg_high_ff, prg_high_in;
   logic       mirror_bit_ff, mirror_bit_in;
   logic [7:0] chr_big_ff [2];
   logic [7:0] chr_big_in [2];
   logic [7:0] chr_small_ff [4];
   logic [7:0] chr_small_in [4];

   // captured request
   cbm_pkg::action_type action_ff, action_in;
   logic [15:0]         addr_ff, addr_in;

   // results
   logic        strobe_ff, strobe_in;
   logic [20:0] mapped_ff, mapped_in;
   logic        mirror_h_ff, mirror_h_in;
   logic        mirror_fixed_ff, mirror_fixed_in;
   logic        is_ram_ff, is_ram_in;

   // derived page counts
   logic [8:0] prg_num, prg_num_m1, prg_num_m2;
   logic [9:0] chr_num;
   logic [8:0] chr_half;

   cbm_pkg::action_type req_act;
   logic [2:0]  req_slot;
   logic [7:0]  dividend;
   logic [9:0]  divisor;
   logic [9:0]  remainder;
   logic        rem_last;

   logic [2:0]  slot;
   logic [7:0]  prg_page;
   logic [8:0]  chr_page;
   logic        four_screen;

   always_comb begin
      prg_num = prg_pages_ff;
      if (prg_pages_ff == '0) prg_num = 9'd1;
      else if (prg_pages_ff > cbm_pkg::MAX_PRG_PAGES) prg_num = cbm_pkg::MAX_PRG_PAGES;
      prg_num_m1 = prg_num - 9'd1;
      prg_num_m2 = prg_num - 9'd2;
      chr_num = chr_pages_ff;
      if (chr_pages_ff > cbm_pkg::MAX_CHR_PAGES) chr_num = cbm_pkg::MAX_CHR_PAGES;
      chr_half = chr_num[9:1];
      if (chr_half == '0) chr_half = 9'd1;
   end

   // configuration writes
   always_comb begin
      prg_pages_in     = prg_pages_ff;
      chr_pages_in     = chr_pages_ff;
      mirror_wiring_in = mirror_wiring_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cbm_pkg::CSR_PRG_PAGES:     prg_pages_in     = csr_write_data[8:0];
            cbm_pkg::CSR_CHR_PAGES:     chr_pages_in     = csr_write_data;
            cbm_pkg::CSR_MIRROR_WIRING: mirror_wiring_in = csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // mapper register writes and reloads take effect as the request is taken
   assign req_act  = cbm_pkg::action_type'(req_action);
   assign req_slot = req_bus_addr[12:10];

   always_comb begin
      prg_low_in    = prg_low_ff;
      prg_high_in   = prg_high_ff;
      mirror_bit_in = mirror_bit_ff;
      chr_big_in    = chr_big_ff;
      chr_small_in  = chr_small_ff;
      if (cmd.load) begin
         case (req_act)
            cbm_pkg::ACT_WRITE: begin
               if (req_bus_addr[15]) begin
                  if (req_bus_addr[13]) begin
                     chr_small_in[req_bus_addr[1:0]] = req_write_data;
                  end else begin
                     case (req_bus_addr[1:0])
                        cbm_pkg::REG_PRG_LOW: begin
                           prg_low_in    = req_write_data[5:0];
                           mirror_bit_in = req_write_data[6];
                        end
                        cbm_pkg::REG_PRG_HIGH: prg_high_in   = req_write_data[5:0];
                        cbm_pkg::REG_CHR_BIG0: chr_big_in[0] = req_write_data;
                        cbm_pkg::REG_CHR_BIG1: chr_big_in[1] = req_write_data;
                        default: ;
                     endcase
                  end
               end
            end
            cbm_pkg::ACT_RELOAD: begin
               prg_low_in      = 6'd0;
               prg_high_in     = 6'd1;
               mirror_bit_in   = (mirror_wiring_ff == cbm_pkg::MIRROR_HORIZONTAL);
               chr_big_in[0]   = 8'd0;
               chr_big_in[1]   = 8'd1;
               chr_small_in[0] = 8'd4;
               chr_small_in[1] = 8'd5;
               chr_small_in[2] = 8'd6;
               chr_small_in[3] = 8'd7;
            end
            default: ;
         endcase
      end
   end

   // operands for the page wrap
   always_comb begin
      dividend = 8'd0;
      divisor  = 10'd1;
      case (req_act)
         cbm_pkg::ACT_PRG: begin
            divisor  = {1'b0, prg_num};
            dividend = (req_bus_addr[14:13] == cbm_pkg::WIN_SEL_LOW) ?
                       {2'b00, prg_low_ff} : {2'b00, prg_high_ff};
         end
         cbm_pkg::ACT_CHR: begin
            if (req_slot[2]) begin
               dividend = chr_small_ff[req_slot[1:0]];
               divisor  = chr_num;
            end else begin
               dividend = chr_big_ff[req_slot[1]];
               divisor  = {1'b0, chr_half};
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      action_in = action_ff;
      addr_in   = addr_ff;
      if (cmd.load) begin
         action_in = req_act;
         addr_in   = req_bus_addr;
      end
   end

   cbm_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .load      (cmd.load),
      .step      (cmd.step),
      .dividend  (dividend),
      .divisor   (divisor),
      .remainder (remainder),
      .last      (rem_last)
   );

   assign status.rem_last = rem_last;

   // result assembly
   assign slot        = addr_ff[12:10];
   assign four_screen = (mirror_wiring_ff == cbm_pkg::MIRROR_FOUR);

   always_comb begin
      case (addr_ff[14:13])
         cbm_pkg::WIN_SEL_LOW,
         cbm_pkg::WIN_SEL_HIGH:     prg_page = remainder[7:0];
         cbm_pkg::WIN_FIXED_PENULT: prg_page = (prg_num >= 9'd2) ? prg_num_m2[7:0] : 8'd0;
         cbm_pkg::WIN_FIXED_LAST:   prg_page = prg_num_m1[7:0];
         default:                   prg_page = 8'd0;
      endcase
      if (chr_pages_ff != '0) begin
         chr_page = slot[2] ? remainder[8:0] : {remainder[7:0], slot[0]};
      end else begin
         // pattern RAM board: selects are masked, not wrapped
         chr_page = slot[2] ? {6'd0, chr_small_ff[slot[1:0]][2:0]}
                            : {6'd0, chr_big_ff[slot[1]][1:0], slot[0]};
      end
   end

   always_comb begin
      strobe_in       = cmd.finish;
      mapped_in       = mapped_ff;
      mirror_h_in     = mirror_h_ff;
      mirror_fixed_in = mirror_fixed_ff;
      is_ram_in       = is_ram_ff;
      if (cmd.finish) begin
         mapped_in = 21'd0;
         is_ram_in = 1'b0;
         case (action_ff)
            cbm_pkg::ACT_PRG: begin
               if (addr_ff[15]) mapped_in = {prg_page, addr_ff[12:0]};
            end
            cbm_pkg::ACT_CHR: begin
               mapped_in = {2'b00, chr_page, addr_ff[9:0]};
               is_ram_in = (chr_pages_ff == '0);
            end
            default: ;
         endcase
         mirror_h_in     = four_screen ? 1'b0 : mirror_bit_ff;
         mirror_fixed_in = four_screen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_pages_ff     <= cbm_pkg::PRG_PAGES_RESET;
         chr_pages_ff     <= cbm_pkg::CHR_PAGES_RESET;
         mirror_wiring_ff <= cbm_pkg::MIRROR_VERTICAL;
         prg_low_ff       <= 6'd0;
         prg_high_ff      <= 6'd1;
         mirror_bit_ff    <= 1'b0;
         chr_big_ff[0]    <= 8'd0;
         chr_big_ff[1]    <= 8'd1;
         chr_small_ff[0]  <= 8'd4;
         chr_small_ff[1]  <= 8'd5;
         chr_small_ff[2]  <= 8'd6;
         chr_small_ff[3]  <= 8'd7;
         strobe_ff        <= 1'b0;
      end else begin
         prg_pages_ff     <= prg_pages_in;
         chr_pages_ff     <= chr_pages_in;
         mirror_wiring_ff <= mirror_wiring_in;
         prg_low_ff       <= prg_low_in;
         prg_high_ff      <= prg_high_in;
         mirror_bit_ff    <= mirror_bit_in;
         chr_big_ff       <= chr_big_in;
         chr_small_ff     <= chr_small_in;
         strobe_ff        <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff       <= action_in;
      addr_ff         <= addr_in;
      mapped_ff       <= mapped_in;
      mirror_h_ff     <= mirror_h_in;
      mirror_fixed_ff <= mirror_fixed_in;
      is_ram_ff       <= is_ram_in;
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_mapped_addr       = mapped_ff;
   assign rsp_mirror_horizontal = mirror_h_ff;
   assign rsp_mirror_fixed      = mirror_fixed_ff;
   assign rsp_chr_is_ram        = is_ram_ff;

endmodule

// ===== rtl/core/cartridge_bank_mapper_unit.sv =====
// Cartridge bank mapper: bank registers plus PRG and CHR address translation.
// Top level; instantiates cbm_ctrl and cbm_datapath, depends on cbm_pkg.
//
// Usage:
//   A request (action, bus address, write data) is taken at a clock edge with
//   start high and busy low. Register writes and reloads take effect at that
//   edge. Every request gives exactly one response, shown on the rsp_ ports
//   for one cycle with rsp_strobe high; the receiver cannot hold it off.
//   The taken request passes a run state, in which a remainder unit retiring
//   two dividend bits per cycle wraps the 8-bit select, then a done state
//   that assembles the address; the response is registered as the done state
//   ends. busy stays high through both states, so no new request is taken
//   before the response is shown; one can be taken while it is shown.
//   The csr_ port writes page counts and mirror wiring; write it only while
//   no request is outstanding.
//   Reset (synchronous, active high) loads the power-on selects, 2 PRG pages,
//   8 CHR pages and vertical wiring, and leaves the block idle.
module cartridge_bank_mapper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_bus_addr,
   input  logic [7:0]  req_write_data,
   output logic        rsp_strobe,
   output logic [20:0] rsp_mapped_addr,
   output logic        rsp_mirror_horizontal,
   output logic        rsp_mirror_fixed,
   output logic        rsp_chr_is_ram,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_write_data
);

   cbm_pkg::cmd_type    cmd;
   cbm_pkg::status_type status;

   cbm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   cbm_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_action            (req_action),
      .req_bus_addr          (req_bus_addr),
      .req_write_data        (req_write_data),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_strobe            (rsp_strobe),
      .rsp_mapped_addr       (rsp_mapped_addr),
      .rsp_mirror_horizontal (rsp_mirror_horizontal),
      .rsp_mirror_fixed      (rsp_mirror_fixed),
      .rsp_chr_is_ram        (rsp_chr_is_ram)
   );

endmodule

// ===== verif/cartridge_bank_mapper_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cartridge_bank_mapper_unit: bus requests, CSR writes, checks.
// Depends on cbm_pkg and the unit's RTL; predicts every response from its own bank state.

class bank_map_tracker;
   localparam logic [15:0] BANK_REG_MASK = 16'hA003;

   typedef struct packed {
      logic [20:0] mapped_addr;
      logic        mirror_horizontal;
      logic        mirror_fixed;
      logic        chr_is_ram;
   } response_type;

   logic [8:0] prg_pages;
   logic [9:0] chr_pages;
   logic [1:0] mirror_wiring;
   logic [5:0] prg_sel_low;
   logic [5:0] prg_sel_high;
   logic       mirror_bit;
   logic [7:0] chr_big[2];
   logic [7:0] chr_small[4];
   response_type pending_responses[$];
   int         errors;

   function new();
      errors        = 0;
      prg_pages     = cbm_pkg::PRG_PAGES_RESET;
      chr_pages     = cbm_pkg::CHR_PAGES_RESET;
      mirror_wiring = cbm_pkg::MIRROR_VERTICAL;
      restore_selects();
   endfunction

   function void restore_selects();
      prg_sel_low  = 6'd0;
      prg_sel_high = 6'd1;
      mirror_bit   = (mirror_wiring == cbm_pkg::MIRROR_HORIZONTAL);
      chr_big[0]   = 8'd0;
      chr_big[1]   = 8'd1;
      for (int i = 0; i < 4; i++) begin
         chr_small[i] = 8'(4 + i);
      end
   endfunction

   function void set_config(logic [1:0] idx, logic [9:0] data);
      case (idx)
         cbm_pkg::CSR_PRG_PAGES:     prg_pages = data[8:0];
         cbm_pkg::CSR_CHR_PAGES:     chr_pages = data;
         cbm_pkg::CSR_MIRROR_WIRING: mirror_wiring = data[1:0];
         default: ;
      endcase
   endfunction

   function void write_bank_register(logic [15:0] addr, logic [7:0] data);
      logic [15:0] sel;
      if (!addr[15]) return;
      sel = addr & BANK_REG_MASK;
      if (sel[13]) begin
         chr_small[sel[1:0]] = data;
      end else begin
         case (sel[1:0])
            cbm_pkg::REG_PRG_LOW: begin
               prg_sel_low = data[5:0];
               mirror_bit  = data[6];
            end
            cbm_pkg::REG_PRG_HIGH: prg_sel_high = data[5:0];
            cbm_pkg::REG_CHR_BIG0: chr_big[0] = data;
            default:               chr_big[1] = data;
         endcase
      end
   endfunction

   function logic [20:0] prg_address(logic [15:0] addr);
      int unsigned count;
      int unsigned page;
      if (!addr[15]) return 21'd0;
      count = prg_pages;
      if (count == 0) count = 1;
      if (count > cbm_pkg::MAX_PRG_PAGES) count = cbm_pkg::MAX_PRG_PAGES;
      case (addr[14:13])
         cbm_pkg::WIN_SEL_LOW:      page = prg_sel_low % count;
         cbm_pkg::WIN_SEL_HIGH:     page = prg_sel_high % count;
         cbm_pkg::WIN_FIXED_PENULT: page = (count >= 2) ? count - 2 : 0;
         default:                   page = count - 1;
      endcase
      return 21'(page * 32'h2000 + addr[12:0]);
   endfunction

   function logic [20:0] chr_address(logic [15:0] addr);
      int unsigned count;
      int unsigned half;
      int unsigned page;
      logic [2:0]  slot;
      slot = addr[12:10];
      if (chr_pages != 0) begin
         count = (chr_pages > cbm_pkg::MAX_CHR_PAGES) ? cbm_pkg::MAX_CHR_PAGES : chr_pages;
         half  = count >> 1;
         if (half == 0) half = 1;
         // 2KB windows: the upper 1KB is the next page, even past the count
         if (!slot[2]) page = (chr_big[slot[1]] % half) * 2 + slot[0];
         else page = chr_small[slot[1:0]] % count;
      end else begin
         if (!slot[2]) page = {chr_big[slot[1]][1:0], slot[0]};
         else page = chr_small[slot[1:0]][2:0];
      end
      return 21'(page * 32'h400 + addr[9:0]);
   endfunction

   function void note_request(cbm_pkg::action_type act, logic [15:0] addr, logic [7:0] data);
      response_type r;
      r = '0;
      case (act)
         cbm_pkg::ACT_WRITE: write_bank_register(addr, data);
         cbm_pkg::ACT_PRG:   r.mapped_addr = prg_address(addr);
         cbm_pkg::ACT_CHR: begin
            r.mapped_addr = chr_address(addr);
            r.chr_is_ram  = (chr_pages == 0);
         end
         default: restore_selects();
      endcase
      // wiring code 3 is not four-screen
      r.mirror_fixed      = (mirror_wiring == cbm_pkg::MIRROR_FOUR);
      r.mirror_horizontal = r.mirror_fixed ? 1'b0 : mirror_bit;
      pending_responses.push_back(r);
   endfunction

   function void flag(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      errors++;
   endfunction

   function void check_response(logic [20:0] mapped, logic horiz, logic fixed, logic ram);
      response_type want;
      if (pending_responses.size() == 0) begin
         $display("%0t: unexpected response: expected none, actual mapped_addr %0h",
                  $time, mapped);
         errors++;
         return;
      end
      want = pending_responses.pop_front();
      if (mapped !== want.mapped_addr) flag("mapped_addr", want.mapped_addr, mapped);
      if (horiz !== want.mirror_horizontal)
         flag("mirror_horizontal", want.mirror_horizontal, horiz);
      if (fixed !== want.mirror_fixed) flag("mirror_fixed", want.mirror_fixed, fixed);
      if (ram !== want.chr_is_ram) flag("chr_is_ram", want.chr_is_ram, ram);
   endfunction

   function int pending();
      return pending_responses.size();
   endfunction
endclass

module cartridge_bank_mapper_unit_tb;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 150;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   cbm_pkg::action_type req_action = cbm_pkg::ACT_WRITE;
   logic [15:0] req_bus_addr = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_strobe;
   logic [20:0] rsp_mapped_addr;
   logic        rsp_mirror_horizontal;
   logic        rsp_mirror_fixed;
   logic        rsp_chr_is_ram;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = cbm_pkg::CSR_PRG_PAGES;
   logic [9:0]  csr_write_data = '0;

   bank_map_tracker tracker = new();
   int quiet_cycles = 0;

   cartridge_bank_mapper_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_bus_addr(req_bus_addr),
      .req_write_data(req_write_data),
      .rsp_strobe(rsp_strobe),
      .rsp_mapped_addr(rsp_mapped_addr),
      .rsp_mirror_horizontal(rsp_mirror_horizontal),
      .rsp_mirror_fixed(rsp_mirror_fixed),
      .rsp_chr_is_ram(rsp_chr_is_ram),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            tracker.check_response(rsp_mapped_addr, rsp_mirror_horizontal,
                                   rsp_mirror_fixed, rsp_chr_is_ram);
         if (csr_write_enable) tracker.set_config(csr_index, csr_write_data);
         if (start && !busy) tracker.note_request(req_action, req_bus_addr, req_write_data);
         if (rsp_strobe || csr_write_enable || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // leaves start high so back-to-back requests need no second assignment
   task automatic issue(cbm_pkg::action_type act, logic [15:0] addr, logic [7:0] data);
      req_action     <= act;
      req_bus_addr   <= addr;
      req_write_data <= data;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic configure(logic [9:0] prg, logic [9:0] chr, logic [9:0] wiring);
      csr_write_enable <= 1'b1;
      csr_index        <= cbm_pkg::CSR_PRG_PAGES;
      csr_write_data   <= prg;
      @(posedge clock);
      csr_index        <= cbm_pkg::CSR_CHR_PAGES;
      csr_write_data   <= chr;
      @(posedge clock);
      csr_index        <= cbm_pkg::CSR_MIRROR_WIRING;
      csr_write_data   <= wiring;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_request();
      int unsigned pick;
      logic [15:0] addr;
      logic [7:0]  data;
      cbm_pkg::action_type act;
      pick = $urandom_range(0, 99);
      addr = 16'($urandom);
      data = 8'($urandom);
      // mostly writes and reads that land in the mapper window
      if (pick < 35) begin
         act = cbm_pkg::ACT_WRITE;
         if ($urandom_range(0, 9) != 0) addr[15] = 1'b1;
      end else if (pick < 60) begin
         act = cbm_pkg::ACT_PRG;
         if ($urandom_range(0, 7) != 0) addr[15] = 1'b1;
      end else if (pick < 95) begin
         act = cbm_pkg::ACT_CHR;
      end else begin
         act = cbm_pkg::ACT_RELOAD;
      end
      issue(act, addr, data);
   endtask

   task automatic directed_requests();
      issue(cbm_pkg::ACT_PRG, 16'h8000, 8'h00);
      issue(cbm_pkg::ACT_PRG, 16'hA000, 8'h00);
      issue(cbm_pkg::ACT_PRG, 16'hC000, 8'h00);
      issue(cbm_pkg::ACT_PRG, 16'hFFFF, 8'hFF);
      issue(cbm_pkg::ACT_PRG, 16'h7FFF, 8'h00);
      issue(cbm_pkg::ACT_PRG, 16'h0000, 8'h00);
      issue(cbm_pkg::ACT_CHR, 16'h0000, 8'h00);
      issue(cbm_pkg::ACT_CHR, 16'h0400, 8'h00);
      issue(cbm_pkg::ACT_CHR, 16'h1FFF, 8'h00);
      issue(cbm_pkg::ACT_CHR, 16'hFFFF, 8'h00);
      // write below the window is dropped
      issue(cbm_pkg::ACT_WRITE, 16'h7FFF, 8'hFF);
      issue(cbm_pkg::ACT_WRITE, 16'h8000, 8'hFF);
      issue(cbm_pkg::ACT_WRITE, 16'h8001, 8'hFF);
      issue(cbm_pkg::ACT_WRITE, 16'h8002, 8'hFF);
      issue(cbm_pkg::ACT_WRITE, 16'h8003, 8'h00);
      issue(cbm_pkg::ACT_WRITE, 16'hA000, 8'hFF);
      issue(cbm_pkg::ACT_WRITE, 16'hE001, 8'h80);
      issue(cbm_pkg::ACT_WRITE, 16'hFFFF, 8'h01);
      issue(cbm_pkg::ACT_PRG, 16'h8000, 8'h00);
      issue(cbm_pkg::ACT_PRG, 16'hA000, 8'h00);
      issue(cbm_pkg::ACT_CHR, 16'h0800, 8'h00);
      issue(cbm_pkg::ACT_CHR, 16'h1C00, 8'h00);
      issue(cbm_pkg::ACT_RELOAD, 16'h0000, 8'h00);
      issue(cbm_pkg::ACT_PRG, 16'h8000, 8'h00);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) begin
            drain();
            case (ph)
               1: configure(10'd0, 10'd0, 10'(cbm_pkg::MIRROR_HORIZONTAL));
               2: configure(10'd1, 10'd1, 10'(cbm_pkg::MIRROR_FOUR));
               3: configure(10'd256, 10'd512, 10'd3);
               4: configure(10'd511, 10'd1023, 10'(cbm_pkg::MIRROR_VERTICAL));
               5: configure(10'd3, 10'd7, 10'(cbm_pkg::MIRROR_HORIZONTAL));
               default:
                  configure(10'($urandom_range(0, 511)),
                            ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(1, 1023)),
                            10'($urandom_range(0, 3)));
            endcase
         end else begin
            directed_requests();
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // no sender gaps in the final phase
            if (ph != PHASES - 1 && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 13));
            random_request();
         end
      end
      drain();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
